>>> src/input_voltage_protection_fsm_macros.svh
// ----------------------------------------------------------------------------
// Input voltage protection assertion macros
// Shared assertion macros that compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef INPUT_VOLTAGE_PROTECTION_FSM_MACROS_SVH
`define INPUT_VOLTAGE_PROTECTION_FSM_MACROS_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define IVP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("input voltage protection assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define IVP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("input voltage protection assertion failed");
`else
`define IVP_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define IVP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> src/ivp_pkg.sv
// ----------------------------------------------------------------------------
// Input voltage protection package
// Types, register map, reset values and helpers of the protection block.
// ----------------------------------------------------------------------------
package ivp_pkg;

    localparam int LEVEL_W = 12;
    localparam int TIME_W  = 16;
    localparam int DT_W    = 10;
    localparam int POWER_W = 16;

    localparam logic [TIME_W-1:0] TIMER_MAX = '1;

    typedef enum logic [1:0] {
        MODE_OFF     = 2'd0,
        MODE_ON      = 2'd1,
        MODE_DERATED = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        CFG_EARLY_ON_LEVEL    = 3'd0,
        CFG_RESTORE_LEVEL     = 3'd1,
        CFG_OFF_LEVEL         = 3'd2,
        CFG_DERATE_LOW        = 3'd3,
        CFG_DERATE_HIGH       = 3'd4,
        CFG_STARTUP_WINDOW_MS = 3'd5,
        CFG_OFF_DELAY_MS      = 3'd6,
        CFG_BASE_POWER        = 3'd7
    } cfg_idx_t;

    localparam logic [LEVEL_W-1:0] RST_EARLY_ON_LEVEL    = 12'd1650;
    localparam logic [LEVEL_W-1:0] RST_RESTORE_LEVEL     = 12'd2100;
    localparam logic [LEVEL_W-1:0] RST_OFF_LEVEL         = 12'd1700;
    localparam logic [LEVEL_W-1:0] RST_DERATE_LOW        = 12'd1750;
    localparam logic [LEVEL_W-1:0] RST_DERATE_HIGH       = 12'd1850;
    localparam logic [TIME_W-1:0]  RST_STARTUP_WINDOW_MS = 16'd5000;
    localparam logic [TIME_W-1:0]  RST_OFF_DELAY_MS      = 16'd3000;
    localparam logic [POWER_W-1:0] RST_BASE_POWER        = 16'd0;

    // Adds elapsed milliseconds to a timer, saturating at full scale.
    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] t,
                                                  input logic [DT_W-1:0] d);
        logic [TIME_W:0] s;
        s = {1'b0, t} + {{(TIME_W + 1 - DT_W){1'b0}}, d};
        return s[TIME_W] ? TIMER_MAX : s[TIME_W-1:0];
    endfunction

endpackage

>>> src/input_voltage_protection_fsm.sv
// ----------------------------------------------------------------------------
// Input voltage protection state machine
// Lamp driver supply protection with off, on and derated modes.
// ----------------------------------------------------------------------------
// Each item carries one supply sample and the milliseconds since the previous
// item. The block takes one item per clock cycle unless the output stalls and
// presents its result in the following cycle from a single result register; a
// new item is accepted whenever that register is empty or its result is taken
// in the same cycle. The user must write the registers through the APB port only
// while no item is in flight; the block itself does not enforce it.
module input_voltage_protection_fsm
    import ivp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // vin_sample[11:0], elapsed_ms[21:12], zero pad
    // Result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // mode[1:0], lamp_enable[2], power_word[18:3],
                                   // power_halved[19], zero pad
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

`include "input_voltage_protection_fsm_macros.svh"

    logic [LEVEL_W-1:0] early_on_level_reg;
    logic [LEVEL_W-1:0] restore_level_reg;
    logic [LEVEL_W-1:0] off_level_reg;
    logic [LEVEL_W-1:0] derate_low_reg;
    logic [LEVEL_W-1:0] derate_high_reg;
    logic [TIME_W-1:0]  startup_window_reg;
    logic [TIME_W-1:0]  off_delay_reg;
    logic [POWER_W-1:0] base_power_reg;

    mode_t              mode_reg;
    mode_t              mode_next;
    logic [TIME_W-1:0]  uptime_reg;
    logic [TIME_W-1:0]  uptime_next;
    logic [TIME_W-1:0]  mode_timer_reg;
    logic [TIME_W-1:0]  mode_timer_next;
    logic               startup_over_reg;
    logic               startup_over_next;
    logic               off_wait_done_reg;
    logic               off_wait_done_next;
    logic               halved_reg;
    logic               halved_next;
    logic [POWER_W-1:0] power_reg;
    logic [POWER_W-1:0] power_next;
    logic               enable_reg;
    logic               enable_next;

    logic               m_tvalid_reg;
    logic [23:0]        m_tdata_reg;

    logic               accept;
    logic               cfg_write;
    cfg_idx_t           cfg_idx;
    logic [LEVEL_W-1:0] vin;
    logic [DT_W-1:0]    dt;
    logic [TIME_W-1:0]  mode_timer_sum;
    logic               window_closed;
    logic               turn_on;
    logic               below_off;
    logic               in_band;

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = cfg_idx_t'(paddr[4:2]);

    assign vin = s_tdata[11:0];
    assign dt  = s_tdata[21:12];

    assign uptime_next    = sat_add(uptime_reg, dt);
    assign mode_timer_sum = sat_add(mode_timer_reg, dt);
    assign window_closed  = startup_over_reg || (uptime_next >= startup_window_reg);
    assign turn_on        = window_closed ? (vin > restore_level_reg)
                                          : (vin > early_on_level_reg);
    assign below_off      = vin < off_level_reg;
    assign in_band        = (vin > derate_low_reg) && (vin < derate_high_reg);

    always_comb
    begin
        prdata = '0;
        unique case (cfg_idx)
            CFG_EARLY_ON_LEVEL:    prdata[LEVEL_W-1:0] = early_on_level_reg;
            CFG_RESTORE_LEVEL:     prdata[LEVEL_W-1:0] = restore_level_reg;
            CFG_OFF_LEVEL:         prdata[LEVEL_W-1:0] = off_level_reg;
            CFG_DERATE_LOW:        prdata[LEVEL_W-1:0] = derate_low_reg;
            CFG_DERATE_HIGH:       prdata[LEVEL_W-1:0] = derate_high_reg;
            CFG_STARTUP_WINDOW_MS: prdata[TIME_W-1:0]  = startup_window_reg;
            CFG_OFF_DELAY_MS:      prdata[TIME_W-1:0]  = off_delay_reg;
            CFG_BASE_POWER:        prdata[POWER_W-1:0] = base_power_reg;
        endcase
    end

    // Next mode for the item at the input.
    always_comb
    begin
        mode_next = mode_reg;
        unique case (mode_reg)
            MODE_OFF:
            begin
                if (off_wait_done_reg && turn_on)
                begin
                    mode_next = MODE_ON;
                end
            end
            MODE_ON:
            begin
                if (below_off)
                begin
                    mode_next = MODE_OFF;
                end
                else if (in_band)
                begin
                    mode_next = MODE_DERATED;
                end
            end
            MODE_DERATED:
            begin
                if (vin > restore_level_reg)
                begin
                    mode_next = MODE_ON;
                end
                else if (below_off)
                begin
                    mode_next = MODE_OFF;
                end
            end
            default:
            begin
                mode_next = MODE_OFF;
            end
        endcase
    end

    // Flags, timers and power word for the item at the input.
    always_comb
    begin
        mode_timer_next    = (mode_next != mode_reg) ? '0 : mode_timer_sum;
        startup_over_next  = window_closed;
        off_wait_done_next = off_wait_done_reg;
        halved_next        = halved_reg;
        power_next         = power_reg;
        enable_next        = enable_reg;
        unique case (mode_reg)
            MODE_OFF:
            begin
                if (!off_wait_done_reg)
                begin
                    if (mode_timer_sum >= off_delay_reg)
                    begin
                        enable_next        = 1'b0;
                        off_wait_done_next = 1'b1;
                    end
                end
                else if (turn_on)
                begin
                    off_wait_done_next = 1'b0;
                end
            end
            MODE_ON:
            begin
                if (halved_reg)
                begin
                    power_next  = {power_reg[POWER_W-2:0], 1'b0};
                    halved_next = 1'b0;
                end
                enable_next = 1'b1;
                if (below_off)
                begin
                    startup_over_next  = 1'b1;
                    off_wait_done_next = 1'b0;
                end
            end
            MODE_DERATED:
            begin
                if (!halved_reg)
                begin
                    halved_next = 1'b1;
                    power_next  = {1'b0, power_reg[POWER_W-1:1]};
                end
                if (mode_next == MODE_OFF)
                begin
                    off_wait_done_next = 1'b0;
                end
            end
            default:
            begin
                off_wait_done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            early_on_level_reg <= RST_EARLY_ON_LEVEL;
            restore_level_reg  <= RST_RESTORE_LEVEL;
            off_level_reg      <= RST_OFF_LEVEL;
            derate_low_reg     <= RST_DERATE_LOW;
            derate_high_reg    <= RST_DERATE_HIGH;
            startup_window_reg <= RST_STARTUP_WINDOW_MS;
            off_delay_reg      <= RST_OFF_DELAY_MS;
            base_power_reg     <= RST_BASE_POWER;
            mode_reg           <= MODE_OFF;
            uptime_reg         <= '0;
            mode_timer_reg     <= '0;
            startup_over_reg   <= 1'b0;
            off_wait_done_reg  <= 1'b1;
            halved_reg         <= 1'b0;
            power_reg          <= RST_BASE_POWER;
            enable_reg         <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg          <= mode_next;
                uptime_reg        <= uptime_next;
                mode_timer_reg    <= mode_timer_next;
                startup_over_reg  <= startup_over_next;
                off_wait_done_reg <= off_wait_done_next;
                halved_reg        <= halved_next;
                enable_reg        <= enable_next;
            end
            if (cfg_write && (cfg_idx == CFG_BASE_POWER))
            begin
                power_reg <= pwdata[POWER_W-1:0];
            end
            else if (accept)
            begin
                power_reg <= power_next;
            end
            if (cfg_write)
            begin
                unique case (cfg_idx)
                    CFG_EARLY_ON_LEVEL:    early_on_level_reg <= pwdata[LEVEL_W-1:0];
                    CFG_RESTORE_LEVEL:     restore_level_reg  <= pwdata[LEVEL_W-1:0];
                    CFG_OFF_LEVEL:         off_level_reg      <= pwdata[LEVEL_W-1:0];
                    CFG_DERATE_LOW:        derate_low_reg     <= pwdata[LEVEL_W-1:0];
                    CFG_DERATE_HIGH:       derate_high_reg    <= pwdata[LEVEL_W-1:0];
                    CFG_STARTUP_WINDOW_MS: startup_window_reg <= pwdata[TIME_W-1:0];
                    CFG_OFF_DELAY_MS:      off_delay_reg      <= pwdata[TIME_W-1:0];
                    CFG_BASE_POWER:        base_power_reg     <= pwdata[POWER_W-1:0];
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (accept)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_tdata_reg <= {4'b0, halved_next, power_next, enable_next, mode_next};
        end
    end

    `IVP_ASSERT_SAME(a_ready_when_empty, clk, rst_n, !m_tvalid_reg, s_tready)
    `IVP_ASSERT_NEXT(a_result_follows_item, clk, rst_n, accept, m_tvalid_reg)
    `IVP_ASSERT_NEXT(a_enable_after_on, clk, rst_n, accept && (mode_reg == MODE_ON),
                     enable_reg)
    `IVP_ASSERT_NEXT(a_window_stays_closed, clk, rst_n, startup_over_reg,
                     startup_over_reg)
    `IVP_ASSERT_NEXT(a_uptime_monotonic, clk, rst_n, accept,
                     uptime_reg >= $past(uptime_reg))
    `IVP_ASSERT_NEXT(a_mode_holds_when_idle, clk, rst_n, !accept, $stable(mode_reg))

endmodule

>>> tb/input_voltage_protection_fsm_checker.sv
// ----------------------------------------------------------------------------
// Input voltage protection checker
// Watches the item, result and register channels of the protection block,
// keeps its own copy of the protection state and registers, predicts the
// status that each accepted sample produces and compares every result with it.
// ----------------------------------------------------------------------------
module input_voltage_protection_fsm_checker
    import ivp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // vin_sample[11:0], elapsed_ms[21:12], zero pad
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // mode[1:0], lamp_enable[2], power_word[18:3],
                                   // power_halved[19], zero pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          errors,
    output int          pending
);

    typedef struct packed {
        logic [1:0]  mode;
        logic        enable;
        logic [15:0] power;
        logic        halved;
    } lamp_status_t;

    logic [11:0] early_lvl;
    logic [11:0] restore_lvl;
    logic [11:0] off_lvl;
    logic [11:0] band_lo;
    logic [11:0] band_hi;
    logic [15:0] window_ms;
    logic [15:0] off_delay;

    mode_t       lamp_mode;
    logic [15:0] uptime;
    logic [15:0] mode_age;
    logic        window_closed;
    logic        off_wait_over;
    logic        halved;
    logic        lamp_on;
    logic [15:0] power;

    lamp_status_t lamp_status_q [$];

    function automatic logic [15:0] timer_add(input logic [15:0] t, input logic [9:0] d);
        logic [16:0] s;
        s = {1'b0, t} + {7'd0, d};
        return (s > 17'h0FFFF) ? 16'hFFFF : s[15:0];
    endfunction

    function automatic void enter(input mode_t m);
        lamp_mode = m;
        mode_age  = '0;
    endfunction

    function automatic lamp_status_t advance_protection(input logic [11:0] vin,
                                                        input logic [9:0] dt);
        lamp_status_t r;
        uptime   = timer_add(uptime, dt);
        mode_age = timer_add(mode_age, dt);
        if (uptime >= window_ms)
            window_closed = 1'b1;
        case (lamp_mode)
            MODE_OFF:
            begin
                if (!off_wait_over)
                begin
                    if (mode_age >= off_delay)
                    begin
                        lamp_on       = 1'b0;
                        off_wait_over = 1'b1;
                    end
                end
                else if ((!window_closed && vin > early_lvl) ||
                         (window_closed && vin > restore_lvl))
                begin
                    enter(MODE_ON);
                    off_wait_over = 1'b0;
                end
            end
            MODE_ON:
            begin
                if (halved)
                begin
                    power  = power << 1;
                    halved = 1'b0;
                end
                lamp_on = 1'b1;
                if (vin < off_lvl)
                begin
                    window_closed = 1'b1;
                    enter(MODE_OFF);
                    off_wait_over = 1'b0;
                end
                else if (vin > band_lo && vin < band_hi)
                    enter(MODE_DERATED);
            end
            MODE_DERATED:
            begin
                if (!halved)
                begin
                    halved = 1'b1;
                    power  = power >> 1;
                end
                if (vin > restore_lvl)
                    enter(MODE_ON);
                else if (vin < off_lvl)
                begin
                    enter(MODE_OFF);
                    off_wait_over = 1'b0;
                end
            end
            default:
            begin
                enter(MODE_OFF);
                off_wait_over = 1'b0;
            end
        endcase
        r.mode   = lamp_mode;
        r.enable = lamp_on;
        r.power  = power;
        r.halved = halved;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lamp_status_t want;
        lamp_status_t got;
        if (!rst_n)
        begin
            early_lvl     = RST_EARLY_ON_LEVEL;
            restore_lvl   = RST_RESTORE_LEVEL;
            off_lvl       = RST_OFF_LEVEL;
            band_lo       = RST_DERATE_LOW;
            band_hi       = RST_DERATE_HIGH;
            window_ms     = RST_STARTUP_WINDOW_MS;
            off_delay     = RST_OFF_DELAY_MS;
            lamp_mode     = MODE_OFF;
            uptime        = '0;
            mode_age      = '0;
            window_closed = 1'b0;
            off_wait_over = 1'b1;
            halved        = 1'b0;
            lamp_on       = 1'b0;
            power         = RST_BASE_POWER;
            lamp_status_q.delete();
            errors        = 0;
            pending       = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = {m_tdata[1:0], m_tdata[2], m_tdata[18:3], m_tdata[19]};
                if (lamp_status_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                end
                else
                begin
                    want = lamp_status_q.pop_front();
                    if (got.mode !== want.mode)
                    begin
                        errors++;
                        $display("%0t: mode mismatch, expected %0d, actual %0d",
                                 $time, want.mode, got.mode);
                    end
                    if (got.enable !== want.enable)
                    begin
                        errors++;
                        $display("%0t: lamp_enable mismatch, expected %0d, actual %0d",
                                 $time, want.enable, got.enable);
                    end
                    if (got.power !== want.power)
                    begin
                        errors++;
                        $display("%0t: power_word mismatch, expected %h, actual %h",
                                 $time, want.power, got.power);
                    end
                    if (got.halved !== want.halved)
                    begin
                        errors++;
                        $display("%0t: power_halved mismatch, expected %0d, actual %0d",
                                 $time, want.halved, got.halved);
                    end
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                case (cfg_idx_t'(paddr[4:2]))
                    CFG_EARLY_ON_LEVEL:    early_lvl   = pwdata[11:0];
                    CFG_RESTORE_LEVEL:     restore_lvl = pwdata[11:0];
                    CFG_OFF_LEVEL:         off_lvl     = pwdata[11:0];
                    CFG_DERATE_LOW:        band_lo     = pwdata[11:0];
                    CFG_DERATE_HIGH:       band_hi     = pwdata[11:0];
                    CFG_STARTUP_WINDOW_MS: window_ms   = pwdata[15:0];
                    CFG_OFF_DELAY_MS:      off_delay   = pwdata[15:0];
                    default:               power       = pwdata[15:0];
                endcase
            end
            if (s_tvalid && s_tready)
                lamp_status_q.push_back(advance_protection(s_tdata[11:0], s_tdata[21:12]));
            pending = lamp_status_q.size();
        end
    end

endmodule

>>> tb/input_voltage_protection_fsm_test.sv
// ----------------------------------------------------------------------------
// Input voltage protection testbench
// Drives supply samples through the protection block under several register
// settings and idle patterns, and lets the checker judge every result.
// ----------------------------------------------------------------------------
module input_voltage_protection_fsm_test;
    import ivp_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int BLOCK_ITEMS = 270;
    localparam int DIRECTED    = 22;

    localparam logic [11:0] DIR_VIN [DIRECTED] = '{
        12'd1000, 12'd1651, 12'd1800, 12'd1800, 12'd2101, 12'd1850, 12'd1750, 12'd1751,
        12'd1700, 12'd2100, 12'd1699, 12'd4095, 12'd4095, 12'd4095, 12'd1651, 12'd1699,
        12'd0,    12'd0,    12'd0,    12'd2000, 12'd4095, 12'd0
    };
    localparam logic [9:0] DIR_DT [DIRECTED] = '{
        10'd0,    10'd10,   10'd10,   10'd10,   10'd10,   10'd5,    10'd5,    10'd5,
        10'd5,    10'd5,    10'd5,    10'd1023, 10'd1023, 10'd1023, 10'd0,    10'd0,
        10'd1023, 10'd1023, 10'd1023, 10'd0,    10'd0,    10'd0
    };

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          errors;
    int          pending;
    int          tx_idle_pct;
    int          rx_idle_pct;
    logic        rx_hold_req;
    logic [11:0] levels [5];

    input_voltage_protection_fsm u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    input_voltage_protection_fsm_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .pready   (pready),
        .errors   (errors),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                hold_left   = 80;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

    task automatic send_item(input logic [11:0] vin, input logic [9:0] dt);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, dt, vin};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_register(input cfg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        if (idx <= CFG_DERATE_HIGH)
            levels[int'(idx)] = value[11:0];
    endtask

    task automatic apply_setting(input int blk);
        int off;
        int lo;
        int hi;
        int restore;
        case (blk)
            1:
            begin
                write_register(CFG_EARLY_ON_LEVEL, 32'd0);
                write_register(CFG_RESTORE_LEVEL, 32'd0);
                write_register(CFG_OFF_LEVEL, 32'd0);
                write_register(CFG_DERATE_LOW, 32'd0);
                write_register(CFG_DERATE_HIGH, 32'd4095);
                write_register(CFG_STARTUP_WINDOW_MS, 32'd0);
                write_register(CFG_OFF_DELAY_MS, 32'd0);
                write_register(CFG_BASE_POWER, 32'hFFFF);
            end
            3:
            begin
                write_register(CFG_EARLY_ON_LEVEL, 32'd4095);
                write_register(CFG_RESTORE_LEVEL, 32'd4094);
                write_register(CFG_OFF_LEVEL, 32'd4095);
                write_register(CFG_DERATE_LOW, 32'd4095);
                write_register(CFG_DERATE_HIGH, 32'd4095);
                write_register(CFG_STARTUP_WINDOW_MS, 32'd65535);
                write_register(CFG_OFF_DELAY_MS, 32'd65535);
                write_register(CFG_BASE_POWER, 32'd0);
            end
            default:
            begin
                off     = $urandom_range(3000, 800);
                lo      = off + $urandom_range(150, 0);
                hi      = lo + $urandom_range(250, 0);
                restore = hi + $urandom_range(400, 0);
                write_register(CFG_EARLY_ON_LEVEL, $urandom_range(3500, 500));
                write_register(CFG_RESTORE_LEVEL, restore);
                write_register(CFG_OFF_LEVEL, off);
                write_register(CFG_DERATE_LOW, lo);
                write_register(CFG_DERATE_HIGH, hi);
                write_register(CFG_STARTUP_WINDOW_MS, $urandom_range(8000, 0));
                write_register(CFG_OFF_DELAY_MS, $urandom_range(4000, 0));
                write_register(CFG_BASE_POWER, {16'd0, 16'($urandom)});
            end
        endcase
    endtask

    // Most samples sit right around one of the current thresholds.
    function automatic logic [11:0] pick_vin();
        int sel;
        int v;
        sel = $urandom_range(99);
        if (sel < 15)
            return 12'($urandom);
        if (sel < 22)
            return ($urandom_range(1) == 1) ? 12'hFFF : 12'h000;
        v = int'(levels[$urandom_range(4)]) + int'($urandom_range(6)) - 3;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return 12'(v);
    endfunction

    function automatic logic [9:0] pick_dt();
        int sel;
        sel = $urandom_range(99);
        if (sel < 35)
            return 10'($urandom_range(15));
        if (sel < 65)
            return 10'($urandom);
        if (sel < 75)
            return 10'd0;
        if (sel < 85)
            return 10'd1023;
        return 10'($urandom_range(600, 100));
    endfunction

    initial
    begin
        int blk;
        int n;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        rx_hold_req = 1'b0;
        tx_idle_pct = 25;
        rx_idle_pct = 55;
        levels[0]   = RST_EARLY_ON_LEVEL;
        levels[1]   = RST_RESTORE_LEVEL;
        levels[2]   = RST_OFF_LEVEL;
        levels[3]   = RST_DERATE_LOW;
        levels[4]   = RST_DERATE_HIGH;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        write_register(CFG_BASE_POWER, 32'h0000_ABCD);
        for (n = 0; n < DIRECTED; n++)
            send_item(DIR_VIN[n], DIR_DT[n]);
        for (blk = 0; blk < 6; blk++)
        begin
            drain_results();
            tx_idle_pct = (blk < 2) ? 25 : ((blk < 4) ? 55 : 0);
            rx_idle_pct = (blk < 2) ? 55 : ((blk < 4) ? 25 : 0);
            apply_setting(blk);
            for (n = 0; n < BLOCK_ITEMS; n++)
            begin
                if (blk == 0 && n == 100)
                    rx_hold_req = 1'b1;
                if (blk == 0 && n == 200)
                    drain_results();
                send_item(pick_vin(), pick_dt());
            end
        end
        drain_results();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> files.f
+incdir+src
src/ivp_pkg.sv
src/input_voltage_protection_fsm.sv
tb/input_voltage_protection_fsm_checker.sv
tb/input_voltage_protection_fsm_test.sv
